### rtl/core/otfn_pkg.sv
// ----------------------------------------------------------------------------
// Oriented triangle face normal: shared constants
// Fixed widths of the normalize, square root and divide datapath, and the
// depth of the queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package otfn_pkg;

  // Result format: signed Q1.30 in a 32-bit word.
  localparam int OUT_W     = 32;
  localparam int NORM_FRAC = 30;

  // Scaled cross product components land in [0, 2^31).
  localparam int R_W       = 31;
  // Sum of three squares of scaled components.
  localparam int SUM_W     = 64;
  // Square root result and its running remainder.
  localparam int S_W       = 32;
  localparam int SQ_REM_W  = 66;
  // Divider numerator, quotient and partial remainder.
  localparam int NUM_W     = 62;
  localparam int Q_W       = 31;
  localparam int DIV_REM_W = 33;

  // Queue between the front and the back.
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;

endpackage

`default_nettype wire

### rtl/core/otfn_if.sv
// ----------------------------------------------------------------------------
// Oriented triangle face normal: channel interfaces
// Valid/ready channels for the triangle input and the normal result.
// ----------------------------------------------------------------------------
`default_nettype none

// Triangle vertices and reference point, signed fixed point.
interface otfn_in_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert0_x;
  logic signed [COORD_BITS-1:0] vert0_y;
  logic signed [COORD_BITS-1:0] vert0_z;
  logic signed [COORD_BITS-1:0] vert1_x;
  logic signed [COORD_BITS-1:0] vert1_y;
  logic signed [COORD_BITS-1:0] vert1_z;
  logic signed [COORD_BITS-1:0] vert2_x;
  logic signed [COORD_BITS-1:0] vert2_y;
  logic signed [COORD_BITS-1:0] vert2_z;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;
  logic signed [COORD_BITS-1:0] ref_z;

  modport source (
    output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
           vert2_x, vert2_y, vert2_z, ref_x, ref_y, ref_z,
    input  ready
  );
  modport sink (
    input  valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
           vert2_x, vert2_y, vert2_z, ref_x, ref_y, ref_z,
    output ready
  );
endinterface

// Oriented unit normal in Q1.30 with its status flags.
interface otfn_out_if import otfn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] norm_x;
  logic signed [OUT_W-1:0] norm_y;
  logic signed [OUT_W-1:0] norm_z;
  logic                    flipped;
  logic                    degenerate;

  modport source (
    output valid, norm_x, norm_y, norm_z, flipped, degenerate,
    input  ready
  );
  modport sink (
    input  valid, norm_x, norm_y, norm_z, flipped, degenerate,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/oriented_triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// Oriented triangle face normal unit
// Throughput: one transaction per cycle unless out_chan.ready stalls the
// back end; set by the fully pipelined back end (32 square root stages and
// 31 divider stages, one bit per stage).
// Reset: synchronous active-low rst_n empties the queue and all valid bits;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_triangle_face_normal_unit import otfn_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  otfn_in_if.sink     in_chan,
  otfn_out_if.source  out_chan
);

  localparam int IW = 9 * (COORD_BITS + 1);

  logic          fr_valid;
  logic          fr_ready;
  logic [IW-1:0] fr_data;
  logic          bk_valid;
  logic          bk_pop;
  logic [IW-1:0] bk_data;

  // Vertex ordering and edge vectors.
  otfn_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item_data  (fr_data)
  );

  // Decoupling queue.
  otfn_queue #(.W(IW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (bk_valid),
    .pop        (bk_pop),
    .pop_data   (bk_data)
  );

  // Normal computation and orientation.
  otfn_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (bk_valid),
    .item_pop   (bk_pop),
    .item_data  (bk_data),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

### rtl/core/otfn_front.sv
// ----------------------------------------------------------------------------
// Oriented triangle face normal: front end
// Accepts a transaction, orders the vertices lexicographically and forms the
// edge vectors and the reference offset into one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module otfn_front import otfn_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  otfn_in_if.sink                          in_chan,
  output logic                             item_valid,
  input  logic                             item_ready,
  output logic [9*(COORD_BITS+1)-1:0]      item_data
);

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  logic                    vld_r;
  logic [9*DW-1:0]         data_r;
  logic [9*DW-1:0]         data_nxt;
  logic                    l12, l23, l13, l32;
  logic signed [CW-1:0]    ax, ay, az, bx, by, bz, cx, cy, cz;

  // Strict lexicographic less-than on x, then y, then z.
  function automatic logic vless(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                                 input logic signed [CW-1:0] pz, input logic signed [CW-1:0] qx,
                                 input logic signed [CW-1:0] qy, input logic signed [CW-1:0] qz);
    logic res;
    if (px != qx) begin
      res = px < qx;
    end else if (py != qy) begin
      res = py < qy;
    end else begin
      res = pz < qz;
    end
    return res;
  endfunction

  assign in_chan.ready = !vld_r || item_ready;
  assign item_valid    = vld_r;
  assign item_data     = data_r;

  // Compare tree that picks the vertex order.
  always_comb begin
    l12 = vless(in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z,
                in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z);
    l23 = vless(in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z,
                in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z);
    l13 = vless(in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z,
                in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z);
    l32 = vless(in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z,
                in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z);
    {ax, ay, az} = {in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z};
    {bx, by, bz} = {in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z};
    {cx, cy, cz} = {in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z};
    if (l12) begin
      if (l23) begin
        {ax, ay, az} = {in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z};
        {bx, by, bz} = {in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z};
        {cx, cy, cz} = {in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z};
      end else if (l13) begin
        {ax, ay, az} = {in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z};
        {bx, by, bz} = {in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z};
        {cx, cy, cz} = {in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z};
      end else begin
        {ax, ay, az} = {in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z};
        {bx, by, bz} = {in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z};
        {cx, cy, cz} = {in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z};
      end
    end else begin
      if (l32) begin
        {ax, ay, az} = {in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z};
        {bx, by, bz} = {in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z};
        {cx, cy, cz} = {in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z};
      end else if (l13) begin
        {ax, ay, az} = {in_chan.vert1_x, in_chan.vert1_y, in_chan.vert1_z};
        {bx, by, bz} = {in_chan.vert0_x, in_chan.vert0_y, in_chan.vert0_z};
        {cx, cy, cz} = {in_chan.vert2_x, in_chan.vert2_y, in_chan.vert2_z};
      end
    end
  end

  // Edge vectors b-a, c-a and reference offset p-a, one bit wider than a coordinate.
  always_comb begin
    data_nxt[0*DW +: DW] = DW'(bx) - DW'(ax);
    data_nxt[1*DW +: DW] = DW'(by) - DW'(ay);
    data_nxt[2*DW +: DW] = DW'(bz) - DW'(az);
    data_nxt[3*DW +: DW] = DW'(cx) - DW'(ax);
    data_nxt[4*DW +: DW] = DW'(cy) - DW'(ay);
    data_nxt[5*DW +: DW] = DW'(cz) - DW'(az);
    data_nxt[6*DW +: DW] = DW'(in_chan.ref_x) - DW'(ax);
    data_nxt[7*DW +: DW] = DW'(in_chan.ref_y) - DW'(ay);
    data_nxt[8*DW +: DW] = DW'(in_chan.ref_z) - DW'(az);
  end

  // Output register toward the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/otfn_queue.sv
// ----------------------------------------------------------------------------
// Oriented triangle face normal: item queue
// Small first-in first-out buffer that lets the front and back stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module otfn_queue import otfn_pkg::*; #(
  parameter int W = 297
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]       mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = cnt_r != (Q_PTR_W+1)'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/otfn_back.sv
// ----------------------------------------------------------------------------
// Oriented triangle face normal: back end
// Pipelined cross product, power-of-two scaling, square root, three dividers,
// orientation test and output register. The whole pipe moves as one.
// ----------------------------------------------------------------------------
`default_nettype none

module otfn_back import otfn_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        item_pop,
  input  logic [9*(COORD_BITS+1)-1:0] item_data,
  otfn_out_if.source                  out_chan
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CRW   = PW + 1;
  localparam int MW    = 2 * CW + 2;
  localparam int TW    = $clog2(MW);
  localparam int PAW   = 3 * DW;
  localparam int DPW   = DW + OUT_W;
  localparam int DSW   = DPW + 2;
  localparam int N_STG = 6 + S_W + 1 + Q_W + 3;

  logic             en;
  logic [N_STG-1:0] vld_r;

  assign en       = !vld_r[N_STG-1] || out_chan.ready;
  assign item_pop = en && item_valid;

  // Valid bits move with the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], item_valid};
    end
  end

  // Stage 1: the six partial products of the cross product.
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] w [3];
  logic signed [PW-1:0] p1_r [6];
  logic [PAW-1:0]       pa1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = item_data[i*DW +: DW];
      w[i] = item_data[(i+3)*DW +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= u[1] * w[2];
      p1_r[1] <= u[2] * w[1];
      p1_r[2] <= u[2] * w[0];
      p1_r[3] <= u[0] * w[2];
      p1_r[4] <= u[0] * w[1];
      p1_r[5] <= u[1] * w[0];
      pa1_r   <= item_data[6*DW +: PAW];
    end
  end

  // Stage 2: cross product components as sign and magnitude.
  logic signed [CRW-1:0] cr [3];
  logic [MW-1:0]         mag2_r [3];
  logic [2:0]            neg2_r;
  logic [PAW-1:0]        pa2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CRW'(p1_r[2*i]) - CRW'(p1_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg2_r[i] <= cr[i][CRW-1];
        mag2_r[i] <= cr[i][CRW-1] ? MW'(-cr[i]) : MW'(cr[i]);
      end
      pa2_r <= pa1_r;
    end
  end

  // Stage 3: leading one of the largest magnitude sets the scale shift.
  logic [MW-1:0] orv;
  logic [TW-1:0] top;
  logic [MW-1:0] mag3_r [3];
  logic [TW-1:0] sh3_r;
  logic          dg3_r;
  logic [2:0]    neg3_r;
  logic [PAW-1:0] pa3_r;

  always_comb begin
    orv = mag2_r[0] | mag2_r[1] | mag2_r[2];
    top = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) begin
        top = TW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag3_r <= mag2_r;
      sh3_r  <= TW'(MW-1) - top;
      dg3_r  <= orv == '0;
      neg3_r <= neg2_r;
      pa3_r  <= pa2_r;
    end
  end

  // Stage 4: align so the largest magnitude falls in [2^30, 2^31), truncating.
  logic [MW-1:0]  aligned [3];
  logic [R_W-1:0] r4_r [3];
  logic           dg4_r;
  logic [2:0]     neg4_r;
  logic [PAW-1:0] pa4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aligned[i] = mag3_r[i] << sh3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r4_r[i] <= aligned[i][MW-1 -: R_W];
      end
      dg4_r  <= dg3_r;
      neg4_r <= neg3_r;
      pa4_r  <= pa3_r;
    end
  end

  // Stage 5: squares of the scaled components.
  logic [2*R_W-1:0] sq5_r [3];
  logic [R_W-1:0]   r5_r [3];
  logic             dg5_r;
  logic [2:0]       neg5_r;
  logic [PAW-1:0]   pa5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= r4_r[i] * r4_r[i];
      end
      r5_r   <= r4_r;
      dg5_r  <= dg4_r;
      neg5_r <= neg4_r;
      pa5_r  <= pa4_r;
    end
  end

  // Stage 6: sum of squares.
  logic [SUM_W-1:0] sum6_r;
  logic [R_W-1:0]   r6_r [3];
  logic             dg6_r;
  logic [2:0]       neg6_r;
  logic [PAW-1:0]   pa6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum6_r <= SUM_W'(sq5_r[0]) + SUM_W'(sq5_r[1]) + SUM_W'(sq5_r[2]);
      r6_r   <= r5_r;
      dg6_r  <= dg5_r;
      neg6_r <= neg5_r;
      pa6_r  <= pa5_r;
    end
  end

  // Square root: one result bit per stage, remainder kept as x - root^2.
  logic [SQ_REM_W-1:0] sq_rem_r  [S_W];
  logic [S_W-1:0]      sq_root_r [S_W];
  logic [R_W-1:0]      sq_rv_r   [S_W][3];
  logic                sq_dg_r   [S_W];
  logic [2:0]          sq_neg_r  [S_W];
  logic [PAW-1:0]      sq_pa_r   [S_W];

  for (genvar j = 0; j < S_W; j++) begin : g_sqrt
    localparam int B = S_W - 1 - j;
    logic [SQ_REM_W-1:0] rem_in;
    logic [S_W-1:0]      root_in;
    logic [SQ_REM_W-1:0] test;
    logic [R_W-1:0]      rv_in [3];
    logic                dg_in;
    logic [2:0]          neg_in;
    logic [PAW-1:0]      pa_in;

    if (j == 0) begin : g_first
      assign rem_in  = SQ_REM_W'(sum6_r);
      assign root_in = '0;
      assign rv_in   = r6_r;
      assign dg_in   = dg6_r;
      assign neg_in  = neg6_r;
      assign pa_in   = pa6_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign rv_in   = sq_rv_r[j-1];
      assign dg_in   = sq_dg_r[j-1];
      assign neg_in  = sq_neg_r[j-1];
      assign pa_in   = sq_pa_r[j-1];
    end

    // Trial adds this bit: (root + 2^B)^2 - root^2.
    assign test = (SQ_REM_W'(root_in) << (B + 1)) + (SQ_REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= test) begin
          sq_rem_r[j]  <= rem_in - test;
          sq_root_r[j] <= root_in | (S_W'(1) << B);
        end else begin
          sq_rem_r[j]  <= rem_in;
          sq_root_r[j] <= root_in;
        end
        sq_rv_r[j]  <= rv_in;
        sq_dg_r[j]  <= dg_in;
        sq_neg_r[j] <= neg_in;
        sq_pa_r[j]  <= pa_in;
      end
    end
  end

  // Divider setup: numerator r * 2^30 plus half the norm for rounding.
  logic [NUM_W-1:0] num [3];
  logic [DIV_REM_W-1:0] d0_rem_r [3];
  logic [Q_W-1:0]   d0_lo_r [3];
  logic [S_W-1:0]   d0_s_r;
  logic             d0_dg_r;
  logic [2:0]       d0_neg_r;
  logic [PAW-1:0]   d0_pa_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUM_W'(sq_rv_r[S_W-1][i]) << NORM_FRAC)
             + NUM_W'(sq_root_r[S_W-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d0_rem_r[i] <= DIV_REM_W'(num[i][NUM_W-1:Q_W]);
        d0_lo_r[i]  <= num[i][Q_W-1:0];
      end
      d0_s_r   <= sq_root_r[S_W-1];
      d0_dg_r  <= sq_dg_r[S_W-1];
      d0_neg_r <= sq_neg_r[S_W-1];
      d0_pa_r  <= sq_pa_r[S_W-1];
    end
  end

  // Restoring division: one quotient bit per stage for all three components.
  logic [DIV_REM_W-1:0] dv_rem_r [Q_W][3];
  logic [Q_W-1:0]       dv_lo_r  [Q_W][3];
  logic [Q_W-1:0]       dv_q_r   [Q_W][3];
  logic [S_W-1:0]       dv_s_r   [Q_W];
  logic                 dv_dg_r  [Q_W];
  logic [2:0]           dv_neg_r [Q_W];
  logic [PAW-1:0]       dv_pa_r  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int NB = Q_W - 1 - k;
    logic [DIV_REM_W-1:0] rem_in [3];
    logic [Q_W-1:0]       lo_in  [3];
    logic [Q_W-1:0]       q_in   [3];
    logic [S_W-1:0]       s_in;
    logic                 dg_in;
    logic [2:0]           neg_in;
    logic [PAW-1:0]       pa_in;
    logic [DIV_REM_W:0]   t [3];
    logic [DIV_REM_W:0]   diff [3];

    if (k == 0) begin : g_first
      assign rem_in = d0_rem_r;
      assign lo_in  = d0_lo_r;
      assign q_in   = '{default: '0};
      assign s_in   = d0_s_r;
      assign dg_in  = d0_dg_r;
      assign neg_in = d0_neg_r;
      assign pa_in  = d0_pa_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[k-1];
      assign lo_in  = dv_lo_r[k-1];
      assign q_in   = dv_q_r[k-1];
      assign s_in   = dv_s_r[k-1];
      assign dg_in  = dv_dg_r[k-1];
      assign neg_in = dv_neg_r[k-1];
      assign pa_in  = dv_pa_r[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {rem_in[i], lo_in[i][NB]};
        diff[i] = t[i] - (DIV_REM_W+1)'(s_in);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= (DIV_REM_W+1)'(s_in)) begin
            dv_rem_r[k][i] <= diff[i][DIV_REM_W-1:0];
            dv_q_r[k][i]   <= {q_in[i][Q_W-2:0], 1'b1};
          end else begin
            dv_rem_r[k][i] <= t[i][DIV_REM_W-1:0];
            dv_q_r[k][i]   <= {q_in[i][Q_W-2:0], 1'b0};
          end
        end
        dv_lo_r[k]  <= lo_in;
        dv_s_r[k]   <= s_in;
        dv_dg_r[k]  <= dg_in;
        dv_neg_r[k] <= neg_in;
        dv_pa_r[k]  <= pa_in;
      end
    end
  end

  // Apply the cross product signs to the quotients.
  logic [OUT_W-1:0]        qx [3];
  logic signed [OUT_W-1:0] sg_n_r [3];
  logic                    sg_dg_r;
  logic [PAW-1:0]          sg_pa_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = OUT_W'(dv_q_r[Q_W-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sg_n_r[i] <= dv_neg_r[Q_W-1][i] ? (~qx[i] + 1'b1) : qx[i];
      end
      sg_dg_r <= dv_dg_r[Q_W-1];
      sg_pa_r <= dv_pa_r[Q_W-1];
    end
  end

  // Orientation products (p - a) . n, one per axis.
  logic signed [DW-1:0]    pa_c [3];
  logic signed [DPW-1:0]   dp_r [3];
  logic signed [OUT_W-1:0] dp_n_r [3];
  logic                    dp_dg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = sg_pa_r[i*DW +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i] <= pa_c[i] * sg_n_r[i];
      end
      dp_n_r  <= sg_n_r;
      dp_dg_r <= sg_dg_r;
    end
  end

  // Output register: flip toward the side away from the reference point.
  logic signed [DSW-1:0]   dot;
  logic                    flip;
  logic signed [OUT_W-1:0] out_n_r [3];
  logic                    out_flip_r;
  logic                    out_dg_r;

  always_comb begin
    dot  = DSW'(dp_r[0]) + DSW'(dp_r[1]) + DSW'(dp_r[2]);
    flip = !dp_dg_r && !dot[DSW-1] && (dot != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dp_dg_r) begin
          out_n_r[i] <= '0;
        end else if (flip) begin
          out_n_r[i] <= -dp_n_r[i];
        end else begin
          out_n_r[i] <= dp_n_r[i];
        end
      end
      out_flip_r <= flip;
      out_dg_r   <= dp_dg_r;
    end
  end

  assign out_chan.valid      = vld_r[N_STG-1];
  assign out_chan.norm_x     = out_n_r[0];
  assign out_chan.norm_y     = out_n_r[1];
  assign out_chan.norm_z     = out_n_r[2];
  assign out_chan.flipped    = out_flip_r;
  assign out_chan.degenerate = out_dg_r;

endmodule

`default_nettype wire
